// ===== rtl/core/dns_name_wire_encoder_unit_assert.svh =====
// Assertion macros for the DNS name wire encoder.
// Each macro checks on the rising edge of clock and is disabled during reset.
`ifndef DNS_NAME_WIRE_ENCODER_UNIT_ASSERT_SVH
`define DNS_NAME_WIRE_ENCODER_UNIT_ASSERT_SVH

// The property must hold in the same cycle as its trigger.
`define DNWE_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// The property must hold in the cycle after its trigger.
`define DNWE_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== rtl/core/dnwe_pkg.sv =====
`default_nettype none
package dnwe_pkg;

   // Longest label, in characters.
   localparam logic [5:0] LABEL_MAX  = 6'd63;
   // Longest encoded name, in bytes, terminator included.
   localparam int         NAME_MAX   = 255;
   // Highest offset at which the terminator may be written.
   localparam logic [8:0] NAME_LIMIT = 9'(NAME_MAX - 1);

   localparam logic [7:0] DOT_CHAR  = 8'h2E;
   localparam logic [7:0] TERM_BYTE = 8'h00;

   // Slots of one item's write bundle, in the order they go out.
   localparam int NUM_SLOTS = 3;
   localparam int SLOT_CHAR = 0;
   localparam int SLOT_LEN  = 1;
   localparam int SLOT_TERM = 2;

   typedef struct packed {
      logic [7:0] wr_offset;
      logic [7:0] wr_byte;
      logic       name_done;
      logic [8:0] name_length;
      logic       overflow;
   } dnwe_write_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]                 mask;
      dnwe_write_type [NUM_SLOTS-1:0]       slot;
   } dnwe_bundle_type;

   typedef struct packed {
      logic           valid;
      logic           run_last;
      dnwe_write_type write;
   } dnwe_emit_type;

endpackage
`default_nettype wire

// ===== rtl/core/dnwe_ifs.sv =====
`default_nettype none
interface dnwe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_name;

   modport source (output valid, output ch, output end_of_name, input ready);
   modport sink   (input valid, input ch, input end_of_name, output ready);
endinterface

interface dnwe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] wr_offset;
   logic [7:0] wr_byte;
   logic       run_last;
   logic       name_done;
   logic [8:0] name_length;
   logic       overflow;

   modport source (output valid, output wr_offset, output wr_byte, output run_last,
                   output name_done, output name_length, output overflow, input ready);
   modport sink   (input valid, input wr_offset, input wr_byte, input run_last,
                   input name_done, input name_length, input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dnwe_label_tracker.sv =====
`default_nettype none
module dnwe_label_tracker
   import dnwe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      ch,
   input  logic            end_of_name,
   output dnwe_bundle_type bundle
);

   logic [7:0] next_offset_ff, next_offset_in;
   logic [7:0] label_start_ff, label_start_in;
   logic [5:0] label_count_ff, label_count_in;
   logic       overflow_seen_ff, overflow_seen_in;

   logic       is_dot;
   logic [7:0] off_mid;
   logic [7:0] start_mid;
   logic [5:0] count_mid;
   logic       ovf_mid;

   always_comb begin
      is_dot    = (ch == DOT_CHAR);
      off_mid   = next_offset_ff;
      start_mid = label_start_ff;
      count_mid = label_count_ff;
      ovf_mid   = overflow_seen_ff;
      bundle    = '0;

      // Character write: opening a label also reserves its length byte.
      if (!is_dot) begin
         if (label_count_ff == 6'd0) begin
            if ({1'b0, next_offset_ff} + 9'd2 <= NAME_LIMIT) begin
               start_mid = next_offset_ff;
               off_mid   = next_offset_ff + 8'd2;
               count_mid = 6'd1;
               bundle.mask[SLOT_CHAR]           = 1'b1;
               bundle.slot[SLOT_CHAR].wr_offset = next_offset_ff + 8'd1;
               bundle.slot[SLOT_CHAR].wr_byte   = ch;
            end else begin
               ovf_mid = 1'b1;
            end
         end else begin
            if (label_count_ff >= LABEL_MAX ||
                {1'b0, next_offset_ff} + 9'd1 > NAME_LIMIT) begin
               ovf_mid = 1'b1;
            end else begin
               off_mid   = next_offset_ff + 8'd1;
               count_mid = label_count_ff + 6'd1;
               bundle.mask[SLOT_CHAR]           = 1'b1;
               bundle.slot[SLOT_CHAR].wr_offset = next_offset_ff;
               bundle.slot[SLOT_CHAR].wr_byte   = ch;
            end
         end
      end

      // Close an open label by writing its length into the reserved byte.
      if ((is_dot || end_of_name) && count_mid != 6'd0) begin
         bundle.mask[SLOT_LEN]           = 1'b1;
         bundle.slot[SLOT_LEN].wr_offset = start_mid;
         bundle.slot[SLOT_LEN].wr_byte   = {2'b00, count_mid};
         count_mid = 6'd0;
      end

      if (end_of_name) begin
         bundle.mask[SLOT_TERM]             = 1'b1;
         bundle.slot[SLOT_TERM].wr_offset   = off_mid;
         bundle.slot[SLOT_TERM].wr_byte     = TERM_BYTE;
         bundle.slot[SLOT_TERM].name_done   = 1'b1;
         bundle.slot[SLOT_TERM].name_length = {1'b0, off_mid} + 9'd1;
         bundle.slot[SLOT_TERM].overflow    = ovf_mid;
      end

      // The terminator returns the tracker to its starting state.
      if (end_of_name) begin
         next_offset_in   = 8'd0;
         label_start_in   = 8'd0;
         label_count_in   = 6'd0;
         overflow_seen_in = 1'b0;
      end else begin
         next_offset_in   = off_mid;
         label_start_in   = start_mid;
         label_count_in   = count_mid;
         overflow_seen_in = ovf_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_offset_ff   <= 8'd0;
         label_start_ff   <= 8'd0;
         label_count_ff   <= 6'd0;
         overflow_seen_ff <= 1'b0;
      end else if (accept) begin
         next_offset_ff   <= next_offset_in;
         label_start_ff   <= label_start_in;
         label_count_ff   <= label_count_in;
         overflow_seen_ff <= overflow_seen_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dnwe_write_sequencer.sv =====
`default_nettype none
module dnwe_write_sequencer
   import dnwe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  dnwe_bundle_type bundle,
   input  logic            rsp_ready,
   output logic            req_ready,
   output dnwe_emit_type   emit
);

   logic [NUM_SLOTS-1:0] pending_ff, pending_in;
   dnwe_write_type [NUM_SLOTS-1:0] slot_ff;

   logic [NUM_SLOTS-1:0] sel_onehot;
   logic [NUM_SLOTS-1:0] remaining;
   logic [1:0]           sel_idx;
   logic                 fire;

   always_comb begin
      sel_onehot = '0;
      sel_idx    = 2'(SLOT_CHAR);
      priority if (pending_ff[SLOT_CHAR]) begin
         sel_onehot[SLOT_CHAR] = 1'b1;
         sel_idx               = 2'(SLOT_CHAR);
      end else if (pending_ff[SLOT_LEN]) begin
         sel_onehot[SLOT_LEN] = 1'b1;
         sel_idx              = 2'(SLOT_LEN);
      end else begin
         sel_onehot[SLOT_TERM] = pending_ff[SLOT_TERM];
         sel_idx               = 2'(SLOT_TERM);
      end

      remaining = pending_ff & ~sel_onehot;
      fire      = (|pending_ff) && rsp_ready;

      emit.valid    = |pending_ff;
      emit.run_last = (remaining == '0);
      emit.write    = slot_ff[sel_idx];

      // A new item may enter while the last write of the previous one leaves.
      req_ready = (pending_ff == '0) || (fire && remaining == '0);

      if (accept) begin
         pending_in = bundle.mask;
      end else if (fire) begin
         pending_in = remaining;
      end else begin
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= bundle.slot;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dns_name_wire_encoder_unit.sv =====
// Latency: the first write of an item appears in the cycle after its transfer.
// Throughput: one write per cycle while the output is ready; an item with zero or one
// writes does not hold the input, an item with two or three holds it until its last write leaves.
// Reset: synchronous, active high; clears the label state and any pending writes.
`default_nettype none
module dns_name_wire_encoder_unit
   import dnwe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dnwe_req_if.sink    req_chan,
   dnwe_rsp_if.source  rsp_chan
);

   // The tracker turns each character into a bundle of up to three writes:
   // the character itself, the length write-back that closes a label, and
   // the terminator. The sequencer holds that bundle and sends its writes
   // out one transfer at a time, in that order.

   logic            accept;
   logic            req_ready;
   dnwe_bundle_type bundle;
   dnwe_emit_type   emit;

   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   dnwe_label_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_chan.ch),
      .end_of_name (req_chan.end_of_name),
      .bundle      (bundle)
   );

   dnwe_write_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .bundle    (bundle),
      .rsp_ready (rsp_chan.ready),
      .req_ready (req_ready),
      .emit      (emit)
   );

   assign rsp_chan.valid       = emit.valid;
   assign rsp_chan.run_last    = emit.run_last;
   assign rsp_chan.wr_offset   = emit.write.wr_offset;
   assign rsp_chan.wr_byte     = emit.write.wr_byte;
   assign rsp_chan.name_done   = emit.write.name_done;
   assign rsp_chan.name_length = emit.write.name_length;
   assign rsp_chan.overflow    = emit.write.overflow;

`include "dns_name_wire_encoder_unit_assert.svh"

   // The terminator is always the final write of its item.
   `DNWE_ASSERT_NOW(a_done_is_last, rsp_chan.valid && rsp_chan.name_done, rsp_chan.run_last, "terminator not last write of item")

   // The reported length counts every byte up to and including the terminator.
   `DNWE_ASSERT_NOW(a_length_matches, rsp_chan.valid && rsp_chan.name_done, rsp_chan.name_length == {1'b0, rsp_chan.wr_offset} + 9'd1, "name length does not match terminator offset")

   // Length and overflow are zero on every write but the terminator.
   `DNWE_ASSERT_NOW(a_status_quiet, rsp_chan.valid && !rsp_chan.name_done, rsp_chan.name_length == 9'd0 && !rsp_chan.overflow, "status fields set on a non-terminator write")

   // A stalled write must stop the input side.
   `DNWE_ASSERT_NOW(a_stall_blocks_input, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "input accepted while a write is stalled")

endmodule
`default_nettype wire
